@@ design/fsos_pkg.sv @@
// Shared constants, types and codes of the first and last occurrence search unit.
`default_nettype none

package fsos_pkg;

    // Table geometry.
    localparam int DEPTH      = 128;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Register file of the configuration port.
    localparam int ACTIVE_W = 8;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam logic [APB_AW-3:0] REG_ACTIVE_COUNT = 1'b0;

    // Stream payload widths.
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SEARCH = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_DONE
    } t_state;

    // Request from the stream side to the search sequencer.
    typedef struct packed {
        logic                  start;
        logic [DATA_WIDTH-1:0] key;
        logic [CNT_W-1:0]      count;
    } t_seq_start;

    // Finished search, held until the output register takes it.
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] last;
    } t_seq_result;

endpackage

`default_nettype wire

@@ design/fsos_ram.sv @@
// Generic single-port RAM with a registered read.
`default_nettype none

module fsos_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

@@ design/fsos_seq.sv @@
// Binary search sequencer: one table probe per cycle, up to two passes per key, the second only after a hit.
`default_nettype none

module fsos_seq import fsos_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_seq_start            i_start,
    input  wire logic                  i_out_free,
    input  wire logic [DATA_WIDTH-1:0] i_rd_data,
    output logic      [IDX_W-1:0]      o_rd_addr,
    output logic                       o_idle,
    output t_seq_result                o_result
);

    t_state           r_state, n_state;
    logic             r_pass;
    logic [CNT_W-1:0] r_lo, r_hp;
    logic [IDX_W-1:0] r_mid;
    logic [DATA_WIDTH-1:0] r_key;
    logic [CNT_W-1:0] r_count;
    logic             r_hit_valid;
    logic [IDX_W-1:0] r_hit;
    logic [IDX_W-1:0] r_first;
    logic [IDX_W-1:0] r_last;
    logic             r_found;

    logic             eq, lt, go_right, more, hit_now;
    logic [CNT_W-1:0] n_lo, n_hp;
    logic [IDX_W-1:0] hit_idx;

    // Midpoint of the half-open window [lo, hp); hp is one past the upper bound.
    function automatic logic [IDX_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                                 input logic [CNT_W-1:0] hp);
        logic [CNT_W-1:0] span;
        logic [CNT_W-1:0] sum;
        span = hp - lo - CNT_W'(1);
        sum  = lo + (span >> 1);
        return sum[IDX_W-1:0];
    endfunction

    // Compare the entry read last cycle and narrow the window.
    always_comb begin
        eq       = (i_rd_data == r_key);
        lt       = ($signed(i_rd_data) < $signed(r_key));
        go_right = lt || (eq && r_pass);
        n_lo     = go_right ? (CNT_W'(r_mid) + CNT_W'(1)) : r_lo;
        n_hp     = go_right ? r_hp : CNT_W'(r_mid);
        more     = (n_lo < n_hp);
        hit_now  = eq || r_hit_valid;
        hit_idx  = eq ? r_mid : r_hit;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start.start) begin
                    n_state = (i_start.count == '0) ? ST_DONE : ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (!more && (r_pass || !hit_now)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_idle         = 1'b0;
        o_rd_addr      = mid_of('0, r_count);
        o_result.valid = 1'b0;
        o_result.found = r_found;
        o_result.first = r_found ? r_first : '0;
        o_result.last  = r_found ? r_last : '0;
        unique case (r_state)
            ST_IDLE: begin
                o_idle    = 1'b1;
                o_rd_addr = mid_of('0, i_start.count);
            end
            ST_PROBE: begin
                if (more) begin
                    o_rd_addr = mid_of(n_lo, n_hp);
                end
            end
            ST_DONE: begin
                o_result.valid = 1'b1;
            end
            default: o_idle = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pass      <= 1'b0;
            r_hit_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start.start) begin
                        r_key       <= i_start.key;
                        r_count     <= i_start.count;
                        r_lo        <= '0;
                        r_hp        <= i_start.count;
                        r_mid       <= mid_of('0, i_start.count);
                        r_pass      <= 1'b0;
                        r_hit_valid <= 1'b0;
                        r_found     <= 1'b0;
                    end
                end
                ST_PROBE: begin
                    if (more) begin
                        r_lo        <= n_lo;
                        r_hp        <= n_hp;
                        r_mid       <= mid_of(n_lo, n_hp);
                        r_hit_valid <= hit_now;
                        r_hit       <= hit_idx;
                    end else if (!r_pass && hit_now) begin
                        // Lowest match known; restart over the whole range for the highest.
                        r_first     <= hit_idx;
                        r_pass      <= 1'b1;
                        r_lo        <= '0;
                        r_hp        <= r_count;
                        r_mid       <= mid_of('0, r_count);
                        r_hit_valid <= 1'b0;
                    end else begin
                        r_found <= r_pass && hit_now;
                        r_last  <= hit_idx;
                    end
                end
                ST_DONE: begin
                    r_pass <= 1'b0;
                end
                default: r_pass <= 1'b0;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/first_last_occurrence_search_unit.sv @@
// Top level of the first and last occurrence search unit over a sorted table.
//
//  Channel   Direction  Handshake                 Payload
//  s_axis    in         tvalid / tready           tuser: command; tdata: index, value
//  m_axis    out        tvalid / tready           tdata: found, first, last, count
//  APB       in         psel, penable, pready     register 0: active_count
//
// A write transfer stores one table entry. A search transfer starts the sequencer, which
// probes the table for each of the two binary searches (at most
// ceil(log2(active_count + 1)) probes each, eight for 128 entries) and then hands off the
// result; the table has a single registered read port. The second
// search is skipped on a miss. s_axis_tready is low while a search runs or its result waits
// for the output register. Reset clears active_count and control state, not the table.
`default_nettype none

module first_last_occurrence_search_unit import fsos_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [6:0] element_index, [38:7] data_value, [39] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] command
    input  wire logic [0:0]            s_axis_tuser,

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [0] found, [7:1] first_index, [14:8] last_index, [22:15] match_count, [23] zero
    output logic      [OUT_DATA_W-1:0] m_axis_tdata,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_AW-1:0]     paddr,
    input  wire logic [APB_DW-1:0]     pwdata,
    output logic      [APB_DW-1:0]     prdata,
    output logic                       pready
);

    logic [ACTIVE_W-1:0]   r_active_count;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                  in_accept;
    logic                  reg_sel;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_addr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [IDX_W-1:0]      seq_addr;
    logic                  seq_idle;
    logic                  out_free;
    logic [CNT_W-1:0]      used_count;
    logic [CNT_W-1:0]      match_count;
    t_seq_start            seq_start;
    t_seq_result           seq_result;

    // Configuration port: one register, written in the access phase.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_AW-1:2] == REG_ACTIVE_COUNT);
    assign prdata  = reg_sel ? APB_DW'(r_active_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_count <= '0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_active_count <= pwdata[ACTIVE_W-1:0];
        end
    end

    // A count beyond the table depth covers the whole table.
    assign used_count = (CNT_W'(DEPTH) < r_active_count) ? CNT_W'(DEPTH)
                                                         : r_active_count[CNT_W-1:0];

    // Input side: writes go straight to the table, searches start the sequencer.
    assign s_axis_tready = seq_idle;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign ram_we        = in_accept && (t_cmd'(s_axis_tuser[0]) == CMD_WRITE);

    assign seq_start.start = in_accept && (t_cmd'(s_axis_tuser[0]) == CMD_SEARCH);
    assign seq_start.key   = s_axis_tdata[IDX_W +: DATA_WIDTH];
    assign seq_start.count = used_count;

    assign ram_addr = ram_we ? s_axis_tdata[IDX_W-1:0] : seq_addr;

    fsos_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (s_axis_tdata[IDX_W +: DATA_WIDTH]),
        .o_rdata (ram_rdata)
    );

    fsos_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (seq_start),
        .i_out_free (out_free),
        .i_rd_data  (ram_rdata),
        .o_rd_addr  (seq_addr),
        .o_idle     (seq_idle),
        .o_result   (seq_result)
    );

    // Output register. The count wraps like the indices when an unsorted
    // table puts the highest match below the lowest.
    assign out_free    = !r_out_valid || m_axis_tready;
    assign match_count = seq_result.found
                       ? (CNT_W'(seq_result.last) - CNT_W'(seq_result.first) + CNT_W'(1))
                       : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_result.valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_result.valid && out_free) begin
            r_out_data <= OUT_DATA_W'({match_count, seq_result.last,
                                       seq_result.first, seq_result.found});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

@@ design/fsos_checker.sv @@
// Port-level checks of the search unit, bound to the top level.
`default_nettype none

module fsos_checker import fsos_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic [0:0]            s_axis_tuser,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // A result that is not taken stays on the bus unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A miss reports zero indices and a zero count.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[OUT_DATA_W-1:1] == '0)
        else $error("miss carries nonzero fields");

    // A hit reports a count of last minus first plus one.
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0]
        |-> m_axis_tdata[22:15] == (m_axis_tdata[14:8] - m_axis_tdata[7:1] + 8'd1))
        else $error("match count disagrees with indices");

    // A search occupies the unit for at least the following cycle.
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (t_cmd'(s_axis_tuser[0]) == CMD_SEARCH)
        |=> !s_axis_tready)
        else $error("input accepted during a search");

endmodule

bind first_last_occurrence_search_unit fsos_checker u_fsos_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
